// ----- design/pcn_pkg.sv -----
// ----------------------------------------------------------------------------
// pcn_pkg
// Shared widths, codes and lane interface types of the pointer coordinate
// normaliser.
// ----------------------------------------------------------------------------
package pcn_pkg;

  // data widths
  localparam int DATA_W     = 32;
  localparam int SCALE_W    = 8;
  localparam int COORD_W    = 12;
  localparam int DIVD_W     = 16;
  localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
  localparam int BUTTON_W   = 8;
  localparam int MASK_W     = 2;
  localparam int SCREEN_X_W = 10;
  localparam int SCREEN_Y_W = 9;

  // screen geometry
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam logic [COORD_W-1:0] TOP_X = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] TOP_Y = COORD_W'(SCREEN_HEIGHT - 1);

  // constants of the mapping
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(10);
  localparam logic [SCALE_W-1:0] DECIMAL     = SCALE_W'(10);
  localparam logic signed [DATA_W-1:0] NEG_LIMIT = -DATA_W'(10);
  localparam int BUTTON_BIT = 7;

  // reciprocal of ten, exact for every dividend below 2^18
  localparam logic [DIVD_W-1:0] TENTH_RECIP = DIVD_W'(52429);
  localparam int                TENTH_SHIFT = 19;

  // operation codes
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_REBASE = 1'b1
  } pcn_func_t;

  // lane sequencer states
  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_MUL,
    LANE_EVAL,
    LANE_DIV,
    LANE_DONE
  } pcn_lane_state_t;

  // what a finished division is used for
  typedef enum logic {
    DIV_CLAMP,
    DIV_REBASE
  } pcn_div_kind_t;

  // command from the top level to one lane
  typedef struct packed {
    logic                start;
    logic                ack;
    pcn_func_t           func;
    logic [DATA_W-1:0]   abs_val;
    logic [DATA_W-1:0]   target;
  } pcn_lane_cmd_t;

  // status from one lane to the merge stage
  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] coord;
  } pcn_lane_res_t;

endpackage

// ----- design/pointer_coordinate_normalizer.sv -----
// ----------------------------------------------------------------------------
// pointer_coordinate_normalizer
// Maps absolute pointer counts to screen coordinates with a per-axis baseline.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_stall stays high until both axis lanes have
// finished and, for a sample, the output register is free. A sample whose axes
// both land on or below the screen passes each lane's multiply and evaluate
// states and shows its result word as in_stall falls; the division by ten is
// a reciprocal multiplication. An axis clamped above the screen, and every
// rebase, also runs the 16-step shift-subtract divider in each lane that
// divides by the sensitivity scale. A stalled result adds its stall to the
// next sample. A finished sample sits in the output register while the next
// word is being worked on. Scale writes of zero are ignored.
// ----------------------------------------------------------------------------
module pointer_coordinate_normalizer (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [pcn_pkg::SCALE_W-1:0]       cfg_wr_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic signed [pcn_pkg::DATA_W-1:0] abs_x,
  input  logic signed [pcn_pkg::DATA_W-1:0] abs_y,
  input  logic [pcn_pkg::BUTTON_W-1:0]      button_left,
  input  logic [pcn_pkg::BUTTON_W-1:0]      button_right,
  input  logic signed [pcn_pkg::DATA_W-1:0] aim_x,
  input  logic signed [pcn_pkg::DATA_W-1:0] aim_y,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pcn_pkg::SCREEN_X_W-1:0]    screen_x,
  output logic [pcn_pkg::SCREEN_Y_W-1:0]    screen_y,
  output logic [pcn_pkg::MASK_W-1:0]        button_bits
);

  logic [pcn_pkg::SCALE_W-1:0]  scale;
  logic                         busy;
  pcn_pkg::pcn_func_t           func_q;
  logic [pcn_pkg::MASK_W-1:0]   mask_q;
  logic                         accept;
  logic                         finish;
  pcn_pkg::pcn_lane_cmd_t       cmd_x, cmd_y;
  pcn_pkg::pcn_lane_res_t       res_x, res_y;

  // handshake
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign finish   = busy && res_x.done && res_y.done &&
                    ((func_q == pcn_pkg::FUNC_REBASE) || !out_valid || !out_stall);

  // lane commands
  always_comb begin
    cmd_x.start   = accept;
    cmd_x.ack     = finish;
    cmd_x.func    = pcn_pkg::pcn_func_t'(func);
    cmd_x.abs_val = abs_x;
    cmd_x.target  = aim_x;
    cmd_y.start   = accept;
    cmd_y.ack     = finish;
    cmd_y.func    = pcn_pkg::pcn_func_t'(func);
    cmd_y.abs_val = abs_y;
    cmd_y.target  = aim_y;
  end

  // scale register, busy flag and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= pcn_pkg::SCALE_RESET;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_wr_data != '0)) begin
        scale <= cfg_wr_data;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish && (func_q == pcn_pkg::FUNC_SAMPLE)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // word held alongside the lanes
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= pcn_pkg::pcn_func_t'(func);
      mask_q <= {button_right[pcn_pkg::BUTTON_BIT], button_left[pcn_pkg::BUTTON_BIT]};
    end
  end

  // merge stage: output register
  always_ff @(posedge clk) begin
    if (finish && (func_q == pcn_pkg::FUNC_SAMPLE)) begin
      screen_x    <= res_x.coord[pcn_pkg::SCREEN_X_W-1:0];
      screen_y    <= res_y.coord[pcn_pkg::SCREEN_Y_W-1:0];
      button_bits <= mask_q;
    end
  end

  pcn_axis_lane u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_x),
    .scale (scale),
    .top   (pcn_pkg::TOP_X),
    .res   (res_x)
  );

  pcn_axis_lane u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_y),
    .scale (scale),
    .top   (pcn_pkg::TOP_Y),
    .res   (res_y)
  );

endmodule

// ----- design/pcn_div.sv -----
// ----------------------------------------------------------------------------
// pcn_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcn_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcn_pkg::DIVD_W-1:0]    dividend,
  input  logic [pcn_pkg::SCALE_W-1:0]   divisor,
  output logic                          done,
  output logic [pcn_pkg::DIVD_W-1:0]    quotient
);

  logic                            running;
  logic [pcn_pkg::DIV_CNT_W-1:0]   cnt;
  logic [pcn_pkg::SCALE_W-1:0]     rem;
  logic [pcn_pkg::SCALE_W-1:0]     dsr;
  logic [pcn_pkg::DIVD_W-1:0]      work;
  logic [pcn_pkg::SCALE_W:0]       trial;
  logic                            fits;
  logic [pcn_pkg::SCALE_W:0]       diff;

  // one trial subtract per step
  always_comb begin
    trial = {rem, work[pcn_pkg::DIVD_W-1]};
    fits  = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == pcn_pkg::DIV_CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= pcn_pkg::DIV_CNT_W'(pcn_pkg::DIVD_W);
      end else if (running) begin
        cnt <= cnt - pcn_pkg::DIV_CNT_W'(1);
        if (cnt == pcn_pkg::DIV_CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (running) begin
      work <= {work[pcn_pkg::DIVD_W-2:0], fits};
      rem  <= fits ? diff[pcn_pkg::SCALE_W-1:0] : trial[pcn_pkg::SCALE_W-1:0];
    end
  end

  assign quotient = work;

endmodule

// ----- design/pcn_axis_lane.sv -----
// ----------------------------------------------------------------------------
// pcn_axis_lane
// One axis of the normaliser: holds the baseline, maps a sample or rebases,
// using its own iterative divider.
// ----------------------------------------------------------------------------
module pcn_axis_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  pcn_pkg::pcn_lane_cmd_t        cmd,
  input  logic [pcn_pkg::SCALE_W-1:0]   scale,
  input  logic [pcn_pkg::COORD_W-1:0]   top,
  output pcn_pkg::pcn_lane_res_t        res
);

  pcn_pkg::pcn_lane_state_t         state, state_next;
  pcn_pkg::pcn_div_kind_t           kind, kind_next;
  logic [pcn_pkg::DATA_W-1:0]       origin;
  logic [pcn_pkg::DATA_W-1:0]       abs_val;
  logic [pcn_pkg::DATA_W-1:0]       prod;
  logic [pcn_pkg::COORD_W-1:0]      coord;

  logic                             div_start;
  logic [pcn_pkg::DIVD_W-1:0]       div_dividend;
  logic [pcn_pkg::SCALE_W-1:0]      div_divisor;
  logic                             div_done;
  logic [pcn_pkg::DIVD_W-1:0]       div_q;

  logic [pcn_pkg::DIVD_W-1:0]       top_x10;
  logic [pcn_pkg::DIVD_W:0]         hi_limit;
  logic [pcn_pkg::COORD_W-1:0]      target_clamp;
  logic [pcn_pkg::DATA_W-1:0]       prod_full;
  logic [2*pcn_pkg::DIVD_W-1:0]     tenth_full;
  logic [pcn_pkg::COORD_W-1:0]      tenth_q;
  logic [pcn_pkg::DATA_W-1:0]       q_ext;
  logic [pcn_pkg::DATA_W-1:0]       q_x10;
  logic                             is_neg_move;
  logic                             is_neg;
  logic                             is_over;

  // constant-ish arithmetic on the screen limit
  always_comb begin
    top_x10  = (pcn_pkg::DIVD_W'(top) << 3) + (pcn_pkg::DIVD_W'(top) << 1);
    hi_limit = {1'b0, top_x10} + (pcn_pkg::DIVD_W + 1)'(pcn_pkg::DECIMAL);
  end

  // target clamp to the screen
  always_comb begin
    if ($signed(cmd.target) > $signed(pcn_pkg::DATA_W'(top))) begin
      target_clamp = top;
    end else if (cmd.target[pcn_pkg::DATA_W-1] || (cmd.target == '0)) begin
      target_clamp = '0;
    end else begin
      target_clamp = cmd.target[pcn_pkg::COORD_W-1:0];
    end
  end

  // scaled motion, range checks and the division by ten
  always_comb begin
    prod_full   = (abs_val - origin) * pcn_pkg::DATA_W'(scale);
    is_neg_move = $signed(prod) <= pcn_pkg::NEG_LIMIT;
    is_neg      = prod[pcn_pkg::DATA_W-1];
    is_over     = prod >= pcn_pkg::DATA_W'(hi_limit);
    tenth_full  = (2 * pcn_pkg::DIVD_W)'(prod[pcn_pkg::DIVD_W-1:0]) *
                  (2 * pcn_pkg::DIVD_W)'(pcn_pkg::TENTH_RECIP);
    tenth_q     = tenth_full[pcn_pkg::TENTH_SHIFT +: pcn_pkg::COORD_W];
    q_ext       = pcn_pkg::DATA_W'(div_q);
    q_x10       = (q_ext << 3) + (q_ext << 1);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcn_pkg::LANE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and divider launch
  always_comb begin
    state_next   = state;
    kind_next    = kind;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = scale;
    unique case (state)
      pcn_pkg::LANE_IDLE: begin
        if (cmd.start) begin
          if (cmd.func == pcn_pkg::FUNC_REBASE) begin
            div_start    = 1'b1;
            div_dividend = pcn_pkg::DIVD_W'(target_clamp);
            kind_next    = pcn_pkg::DIV_REBASE;
            state_next   = pcn_pkg::LANE_DIV;
          end else begin
            state_next = pcn_pkg::LANE_MUL;
          end
        end
      end
      pcn_pkg::LANE_MUL: begin
        state_next = pcn_pkg::LANE_EVAL;
      end
      pcn_pkg::LANE_EVAL: begin
        if (is_over && !is_neg) begin
          div_start    = 1'b1;
          div_dividend = top_x10;
          kind_next    = pcn_pkg::DIV_CLAMP;
          state_next   = pcn_pkg::LANE_DIV;
        end else begin
          state_next = pcn_pkg::LANE_DONE;
        end
      end
      pcn_pkg::LANE_DIV: begin
        if (div_done) begin
          state_next = pcn_pkg::LANE_DONE;
        end
      end
      pcn_pkg::LANE_DONE: begin
        if (cmd.ack) begin
          state_next = pcn_pkg::LANE_IDLE;
        end
      end
      default: begin
        state_next = pcn_pkg::LANE_IDLE;
      end
    endcase
  end

  // baseline, held as architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
    end else begin
      if ((state == pcn_pkg::LANE_EVAL) && is_neg_move) begin
        origin <= abs_val;
      end else if ((state == pcn_pkg::LANE_DIV) && div_done) begin
        if (kind == pcn_pkg::DIV_CLAMP) begin
          origin <= abs_val - q_ext;
        end else begin
          origin <= abs_val - q_x10;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    kind <= kind_next;
    if ((state == pcn_pkg::LANE_IDLE) && cmd.start) begin
      abs_val <= cmd.abs_val;
    end
    if (state == pcn_pkg::LANE_MUL) begin
      prod <= prod_full;
    end
    if (state == pcn_pkg::LANE_EVAL) begin
      if (is_neg) begin
        coord <= '0;
      end else if (is_over) begin
        coord <= top;
      end else begin
        coord <= tenth_q;
      end
    end
  end

  pcn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign res.done  = (state == pcn_pkg::LANE_DONE);
  assign res.coord = coord;

endmodule
